### rtl/rx_ring_buffer_overflow_policy_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the receive ring buffer
// Clocked on i_clk, muted while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RX_RING_BUFFER_OVERFLOW_POLICY_MACROS_SVH
`define RX_RING_BUFFER_OVERFLOW_POLICY_MACROS_SVH

// Same-cycle implication
`define RXRB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RXRB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rxrb_pkg.sv
// ----------------------------------------------------------------------------
// rxrb_pkg
// Sizes, marker ROM and controller/datapath interface types for the
// receive ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package rxrb_pkg;

    localparam int DEPTH        = 64;
    localparam int MARKER_LEN   = 19;
    localparam int MK_ROM_LEN   = 31;
    localparam int MK_ROM_W     = 5;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int MK_W         = $clog2(MARKER_LEN + 1);
    localparam int FREE_OUT_W   = 7;
    localparam int CALC_W       = (CNT_W > FREE_OUT_W) ? CNT_W : FREE_OUT_W;

    localparam logic ACT_RX   = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Overflow marker text, zero padded
    localparam logic [7:0] MARKER_ROM [0:MK_ROM_LEN-1] = '{
        8'h3C, 8'h44, 8'h41, 8'h50, 8'h4C, 8'h69, 8'h6E, 8'h6B, 8'h3A, 8'h4F,
        8'h76, 8'h65, 8'h72, 8'h66, 8'h6C, 8'h6F, 8'h77, 8'h3E, 8'h0A,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00
    };

    // Commands from controller to datapath
    typedef struct packed {
        logic push_rx;      // store the received byte
        logic drop_old;     // discard the oldest entry
        logic rd_en;        // pop the oldest entry into the read register
        logic mk_write;     // store the next marker byte
        logic load;         // capture a result
        logic res_valid;    // result carries a popped byte
        logic res_dropped;
        logic res_marker;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic free_gt_ml;
        logic free_eq_ml;
        logic detect;
        logic mk_last;
    } t_stat;

endpackage

`default_nettype wire

### rtl/rxrb_dp.sv
// ----------------------------------------------------------------------------
// rxrb_dp
// Ring buffer storage, pointers, fill count, marker sequencer, policy
// register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rx_ring_buffer_overflow_policy_macros.svh"

module rxrb_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_data,
    input  wire logic [7:0]                      i_rx_byte,
    input  wire rxrb_pkg::t_cmd                  i_cmd,
    output rxrb_pkg::t_stat                      o_stat,
    output logic                                 o_out_valid,
    output logic [7:0]                           o_out_byte,
    output logic [rxrb_pkg::FREE_OUT_W-1:0]      o_free_slots,
    output logic                                 o_byte_dropped,
    output logic                                 o_marker_inserted
);

    logic [7:0]                    fifo_mem [0:rxrb_pkg::DEPTH-1];
    logic [rxrb_pkg::PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [rxrb_pkg::PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [rxrb_pkg::CNT_W-1:0]    r_fill, n_fill;
    logic [rxrb_pkg::MK_W-1:0]     r_mk_idx, n_mk_idx;
    logic                          r_detect;
    logic [7:0]                    r_rd_data;
    logic                          push, pop;
    logic [7:0]                    wr_data;
    logic [rxrb_pkg::CALC_W-1:0]   free_now, free_next;

    // Policy register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect <= 1'b0;
        end else if (i_cfg_we) begin
            r_detect <= i_cfg_data;
        end
    end

    // Select write data and pointer moves
    assign push    = i_cmd.push_rx | i_cmd.mk_write;
    assign pop     = i_cmd.rd_en | i_cmd.drop_old;
    assign wr_data = i_cmd.push_rx ? i_rx_byte
                                   : rxrb_pkg::MARKER_ROM[rxrb_pkg::MK_ROM_W'(r_mk_idx)];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_mk_idx = r_mk_idx;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == rxrb_pkg::PTR_W'(rxrb_pkg::DEPTH - 1))
                     ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == rxrb_pkg::PTR_W'(rxrb_pkg::DEPTH - 1))
                     ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_cmd.mk_write) begin
            n_mk_idx = o_stat.mk_last ? '0 : r_mk_idx + 1'b1;
        end
        n_fill = r_fill + rxrb_pkg::CNT_W'(push) - rxrb_pkg::CNT_W'(pop);
    end

    // Advance pointers, count and marker index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_mk_idx <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
            r_mk_idx <= n_mk_idx;
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (push) begin
            fifo_mem[r_wr_ptr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= fifo_mem[r_rd_ptr];
        end
    end

    // Status
    assign free_now  = rxrb_pkg::CALC_W'(rxrb_pkg::DEPTH) - rxrb_pkg::CALC_W'(r_fill);
    assign free_next = rxrb_pkg::CALC_W'(rxrb_pkg::DEPTH) - rxrb_pkg::CALC_W'(n_fill);

    assign o_stat.empty      = (r_fill == '0);
    assign o_stat.free_gt_ml = (free_now > rxrb_pkg::CALC_W'(rxrb_pkg::MARKER_LEN));
    assign o_stat.free_eq_ml = (free_now == rxrb_pkg::CALC_W'(rxrb_pkg::MARKER_LEN));
    assign o_stat.detect     = r_detect;
    assign o_stat.mk_last    = (r_mk_idx == rxrb_pkg::MK_W'(rxrb_pkg::MARKER_LEN - 1));

    // Result register: hold until the next load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_out_valid       <= i_cmd.res_valid;
            o_out_byte        <= i_cmd.res_valid ? r_rd_data : 8'h00;
            o_free_slots      <= free_next[rxrb_pkg::FREE_OUT_W-1:0];
            o_byte_dropped    <= i_cmd.res_dropped;
            o_marker_inserted <= i_cmd.res_marker;
        end
    end

    `RXRB_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= rxrb_pkg::CNT_W'(rxrb_pkg::DEPTH),
        "fill count beyond depth")
    `RXRB_ASSERT_IMP(a_no_pop_empty, i_cmd.rd_en, r_fill != '0, "pop from empty buffer")
    `RXRB_ASSERT_NXT(a_marker_fills, i_cmd.mk_write && o_stat.mk_last,
        r_fill == rxrb_pkg::CNT_W'(rxrb_pkg::DEPTH), "marker did not fill the buffer")

endmodule

`default_nettype wire

### rtl/rxrb_ctrl.sv
// ----------------------------------------------------------------------------
// rxrb_ctrl
// Sequencer for the receive ring buffer: takes one item, applies the
// overflow policy, runs the marker write and the memory read, and owns the
// result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rxrb_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_item_valid,
    output logic                  o_item_stall,
    input  wire logic             i_action,
    output logic                  o_res_valid,
    input  wire logic             i_res_stall,
    input  wire rxrb_pkg::t_stat  i_stat,
    output rxrb_pkg::t_cmd        o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MARK = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_res_valid, n_res_valid;
    logic       slot_free;
    logic       accept;

    // Result slot empties by the next edge
    assign slot_free    = !r_res_valid || !i_res_stall;
    assign accept       = (r_state == S_IDLE) && slot_free && i_item_valid;
    assign o_item_stall = !((r_state == S_IDLE) && slot_free);
    assign o_res_valid  = r_res_valid;

    // Decode policy and sequence
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == rxrb_pkg::ACT_READ) begin
                        if (i_stat.empty) begin
                            o_cmd.load = 1'b1;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_READ;
                        end
                    end else if (i_stat.free_gt_ml) begin
                        o_cmd.push_rx = 1'b1;
                        o_cmd.load    = 1'b1;
                    end else if (i_stat.detect) begin
                        if (i_stat.free_eq_ml) begin
                            n_state = S_MARK;
                        end else begin
                            o_cmd.res_dropped = 1'b1;
                            o_cmd.load        = 1'b1;
                        end
                    end else begin
                        o_cmd.drop_old = !i_stat.empty;
                        o_cmd.push_rx  = 1'b1;
                        o_cmd.load     = 1'b1;
                    end
                end
            end
            S_MARK: begin
                o_cmd.mk_write = 1'b1;
                if (i_stat.mk_last) begin
                    o_cmd.load        = 1'b1;
                    o_cmd.res_dropped = 1'b1;
                    o_cmd.res_marker  = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.load      = 1'b1;
                o_cmd.res_valid = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, drop on transfer
    always_comb begin
        n_res_valid = r_res_valid;
        if (r_res_valid && !i_res_stall) begin
            n_res_valid = 1'b0;
        end
        if (o_cmd.load) begin
            n_res_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/rx_ring_buffer_overflow_policy.sv
// Timing: a stored, dropped or drop-oldest byte and an empty read give the
//   result in the cycle after transfer; a read with data passes the registered
//   memory read, then the result register; a marker insertion enters the marker
//   sequence, then writes one marker byte per cycle, MARKER_LEN bytes in all.
// Throughput: one item at a time; the next item is taken when the result slot frees.
// Reset: synchronous active-low clears pointers, count, policy and the result valid;
//   buffer contents and the result register are not cleared.
// ----------------------------------------------------------------------------
// rx_ring_buffer_overflow_policy
// Receive byte FIFO with overflow marker or drop-oldest policy.
// ----------------------------------------------------------------------------
`default_nettype none

module rx_ring_buffer_overflow_policy (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic                            i_cfg_data,
    input  wire logic                            i_item_valid,
    output logic                                 o_item_stall,
    input  wire logic                            i_action,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_stall,
    output logic                                 o_out_valid,
    output logic [7:0]                           o_out_byte,
    output logic [rxrb_pkg::FREE_OUT_W-1:0]      o_free_slots,
    output logic                                 o_byte_dropped,
    output logic                                 o_marker_inserted
);

    rxrb_pkg::t_cmd  cmd;
    rxrb_pkg::t_stat stat;

    // Policy register takes any write
    assign o_cfg_ready = 1'b1;

    rxrb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .o_item_stall (o_item_stall),
        .i_action     (i_action),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    rxrb_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_out_byte        (o_out_byte),
        .o_free_slots      (o_free_slots),
        .o_byte_dropped    (o_byte_dropped),
        .o_marker_inserted (o_marker_inserted)
    );

endmodule

`default_nettype wire
